// ----- design/lps_pkg.sv -----
package lps_pkg;

  localparam int MAX_SIZE   = 8;
  localparam int ELEM_W     = 4;
  localparam int SIZE_W     = 4;
  localparam int IDX_W      = $clog2(MAX_SIZE);
  localparam int SIZE_RESET = 3;
  localparam int TDATA_W    = MAX_SIZE * ELEM_W;

  typedef logic [MAX_SIZE-1:0][ELEM_W-1:0] perm_t;

  typedef struct packed {
    perm_t elem;
    logic  is_final;
  } result_t;

  // 1, 2, .. MAX_SIZE in positions 0 upwards
  function automatic perm_t identity_perm();
    perm_t p;
    for (int i = 0; i < MAX_SIZE; i++) begin
      p[i] = ELEM_W'(i + 1);
    end
    return p;
  endfunction

  // clamp a written size into 1..MAX_SIZE
  function automatic logic [SIZE_W-1:0] sat_size(input logic [SIZE_W-1:0] v);
    logic [SIZE_W-1:0] s;
    s = v;
    if (v == '0) begin
      s = SIZE_W'(1);
    end else if (v > SIZE_W'(MAX_SIZE)) begin
      s = SIZE_W'(MAX_SIZE);
    end
    return s;
  endfunction

endpackage

// ----- design/lps_succ.sv -----
// Next permutation: rightmost ascent as pivot, swap with rightmost larger
// element after it, reverse the suffix. Wraps to identity from descending or on load_id.
module lps_succ import lps_pkg::*; (
  input  perm_t             cur,
  input  logic [SIZE_W-1:0] size,
  input  logic              load_id,
  output perm_t             nxt,
  output result_t           res
);

  localparam int SUM_W = SIZE_W + 1;

  logic [IDX_W-1:0]  piv;
  logic [IDX_W-1:0]  swp;
  logic              found;
  logic [ELEM_W-1:0] pv;
  logic [SUM_W-1:0]  rsum;
  logic [IDX_W-1:0]  r;
  logic              fin;

  always_comb begin
    piv   = '0;
    found = 1'b0;
    for (int j = 0; j < MAX_SIZE - 1; j++) begin
      if (SIZE_W'(j + 1) < size && cur[j] < cur[j + 1]) begin
        piv   = IDX_W'(j);
        found = 1'b1;
      end
    end
    pv = cur[piv];

    swp = piv;
    for (int k = 1; k < MAX_SIZE; k++) begin
      if (IDX_W'(k) > piv && SIZE_W'(k) < size && cur[k] > pv) begin
        swp = IDX_W'(k);
      end
    end

    rsum = '0;
    r    = '0;
    for (int i = 0; i < MAX_SIZE; i++) begin
      nxt[i] = cur[i];
      if (IDX_W'(i) == piv) begin
        nxt[i] = cur[swp];
      end else if (IDX_W'(i) > piv && SIZE_W'(i) < size) begin
        // mirrored place within the suffix piv+1 .. size-1
        rsum = SUM_W'(size) + SUM_W'(piv) - SUM_W'(i);
        r    = rsum[IDX_W-1:0];
        nxt[i] = (r == swp) ? pv : cur[r];
      end
    end

    if (load_id || !found) begin
      nxt = identity_perm();
    end

    fin = 1'b1;
    for (int k = 0; k < MAX_SIZE - 1; k++) begin
      if (SIZE_W'(k + 1) < size && nxt[k] < nxt[k + 1]) begin
        fin = 1'b0;
      end
    end

    for (int i = 0; i < MAX_SIZE; i++) begin
      res.elem[i] = (SIZE_W'(i) < size) ? nxt[i] : '0;
    end
    res.is_final = fin;
  end

endmodule

// ----- design/lps_out_stage.sv -----
// Result register; refills in the cycle it is taken.
module lps_out_stage import lps_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  result_t             in_data,
  output logic                m_tvalid,
  input  logic                m_tready,
  output logic [TDATA_W-1:0]  m_tdata,
  output logic                m_tlast
);

  logic    valid;
  result_t data;

  assign in_ready = !valid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_ready) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      data <= in_data;
    end
  end

  assign m_tvalid = valid;
  assign m_tdata  = data.elem;
  assign m_tlast  = data.is_final;

endmodule

// ----- design/lexicographic_permutation_stepper.sv -----
// Channel   | Dir | Signals                        | Contents
// ----------+-----+--------------------------------+--------------------------------
// request   | in  | s_tvalid s_tready s_tdata[7:0] | bit 0 restart, rest zero
// result    | out | m_tvalid m_tready m_tdata      | elem_0..elem_7, 4 bits each,
//           |     | m_tlast                        |   elem_0 lowest; tlast = is_final
// config    | in  | cfg_we cfg_wdata[3:0]          | perm_size, saturated to 1..8
//
// One request per cycle while s_tready is high; each result is registered on its transfer and shown in the next cycle.
// The successor is a single combinational pass from the held permutation
// to the result register; the held permutation updates on each transfer.
// s_tready drops only while a result waits and m_tready is low.
// Reset (sync, active high): size 3, identity held, next request restarts.
// A size write also forces the next request to give the identity.
module lexicographic_permutation_stepper import lps_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  output logic                s_tready,
  input  logic [7:0]          s_tdata,   // [0] restart, [7:1] zero
  output logic                m_tvalid,
  input  logic                m_tready,
  output logic [TDATA_W-1:0]  m_tdata,   // [3:0] elem_0 .. [31:28] elem_7
  output logic                m_tlast,   // is_final
  input  logic                cfg_we,
  input  logic [SIZE_W-1:0]   cfg_wdata  // perm_size
);

  // held state
  logic [SIZE_W-1:0] perm_size;
  perm_t             current_perm;
  logic              have_started;

  perm_t             perm_next;
  result_t           res;
  logic              take;

  assign take = s_tvalid && s_tready;

  lps_succ u_succ (
    .cur     (current_perm),
    .size    (perm_size),
    .load_id (s_tdata[0] || !have_started),
    .nxt     (perm_next),
    .res     (res)
  );

  // config writes must arrive only while idle; the block does not enforce this, and a write wins over a transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      perm_size    <= SIZE_W'(SIZE_RESET);
      current_perm <= identity_perm();
      have_started <= 1'b0;
    end else if (cfg_we) begin
      perm_size    <= sat_size(cfg_wdata);
      have_started <= 1'b0;
    end else if (take) begin
      current_perm <= perm_next;
      have_started <= 1'b1;
    end
  end

  lps_out_stage u_out (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .in_data  (res),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

endmodule

// ----- design/lps_chk.sv -----
module lps_chk (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic [7:0]  s_tdata,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [31:0] m_tdata,
  input logic        m_tlast
);

  // stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    else $error("result changed under stall");

  // every request transfer shows up in the next cycle
  a_lat: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> m_tvalid)
    else $error("result missing after request");

  // restart gives the identity, so position 0 holds 1
  a_restart: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && s_tdata[0] |=> m_tdata[3:0] == 4'd1)
    else $error("restart did not give identity");

  // position 0 is always in use
  a_elem0: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[3:0] != 4'd0)
    else $error("elem_0 zero");

  // a single element permutation is always the last one
  a_single: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[7:4] == 4'd0 |-> m_tlast)
    else $error("size one result not flagged final");

endmodule

bind lexicographic_permutation_stepper lps_chk u_lps_chk (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .s_tdata  (s_tdata),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tlast  (m_tlast)
);

// ----- sim/lexicographic_permutation_stepper_tb.sv -----
`timescale 1ns / 100ps

module lexicographic_permutation_stepper_tb;
  import lps_pkg::*;

  // Clock and reset
  logic clk = 1'b0;
  logic rst = 1'b1;

  // Request side: s_tdata holds restart in bit 0, the rest zero
  logic                s_tvalid  = 1'b0;
  logic                s_tready;
  logic [7:0]          s_tdata   = '0;   // [0] restart, [7:1] zero

  // Result side: m_tdata holds elem_0 .. elem_7 from the lowest nibble up
  logic                m_tvalid;
  logic                m_tready  = 1'b0;
  logic [TDATA_W-1:0]  m_tdata;          // [3:0] elem_0 .. [31:28] elem_7
  logic                m_tlast;          // is_final

  // Size register write port
  logic                cfg_we    = 1'b0;
  logic [SIZE_W-1:0]   cfg_wdata = '0;   // perm_size

  // Idling percentages, changed between random phases
  int src_idle_pct   = 0;
  int sink_stall_pct = 0;
  int fail_count     = 0;

  // Own copy of the block's state for prediction
  logic [ELEM_W-1:0] held_perm [MAX_SIZE];
  bit                perm_started;
  int                perm_n;

  // Permutations waiting to come out, oldest first
  result_t expected_perms [$];

  lexicographic_permutation_stepper u_top (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Fill every held entry with 1..MAX_SIZE
  function automatic void load_identity_perm();
    for (int k = 0; k < MAX_SIZE; k++) begin
      held_perm[k] = ELEM_W'(k + 1);
    end
  endfunction

  // Work out the permutation that one accepted request produces.
  // Successor rule: rightmost ascent is the pivot, swap it with the rightmost
  // larger entry to its right, then reverse everything after the pivot.
  // No ascent at all means the descending permutation, so wrap to identity.
  function automatic result_t next_permutation(input bit restart);
    result_t           r;
    int                piv;
    int                j;
    int                lo;
    int                hi;
    bit                found;
    logic [ELEM_W-1:0] t;
    if (restart || !perm_started) begin
      load_identity_perm();
      perm_started = 1'b1;
    end else begin
      found = 1'b0;
      piv   = 0;
      for (j = 0; j + 1 < perm_n; j++) begin
        if (held_perm[j] < held_perm[j+1]) begin
          piv   = j;
          found = 1'b1;
        end
      end
      if (!found) begin
        load_identity_perm();
      end else begin
        j = perm_n - 1;
        while (j > piv && held_perm[j] <= held_perm[piv]) j--;
        t              = held_perm[piv];
        held_perm[piv] = held_perm[j];
        held_perm[j]   = t;
        lo = piv + 1;
        hi = perm_n - 1;
        while (lo < hi) begin
          t             = held_perm[lo];
          held_perm[lo] = held_perm[hi];
          held_perm[hi] = t;
          lo++;
          hi--;
        end
      end
    end
    // unused positions read as zero
    for (j = 0; j < MAX_SIZE; j++) begin
      r.elem[j] = (j < perm_n) ? held_perm[j] : '0;
    end
    r.is_final = 1'b1;
    for (j = 0; j + 1 < perm_n; j++) begin
      if (held_perm[j] < held_perm[j+1]) r.is_final = 1'b0;
    end
    return r;
  endfunction

  // Random size code: mostly small sizes so that wraps happen often,
  // now and then zero or an oversize code to exercise the clamp.
  function automatic logic [SIZE_W-1:0] random_size_code();
    int r;
    r = $urandom_range(99);
    if (r < 5) return '0;
    if (r < 12) return SIZE_W'($urandom_range(15, MAX_SIZE + 1));
    if (r < 70) return SIZE_W'($urandom_range(4, 1));
    if (r < 90) return SIZE_W'($urandom_range(6, 5));
    return SIZE_W'($urandom_range(MAX_SIZE, 7));
  endfunction

  // Size write, only once every outstanding permutation has come out.
  // Spare cycles then pass before cfg_we is raised.
  task automatic write_size(input logic [SIZE_W-1:0] code);
    int v;
    while (expected_perms.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= code;
    @(posedge clk);
    cfg_we    <= 1'b0;
    v = int'(code);
    if (v < 1) v = 1;
    if (v > MAX_SIZE) v = MAX_SIZE;
    perm_n       = v;
    perm_started = 1'b0;
  endtask

  // One request transfer; sender gaps come before tvalid is raised so the
  // valid line is never lowered and raised within one step.
  task automatic send_request(input bit restart);
    while ($urandom_range(99) < src_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {7'b0, restart};
    do @(posedge clk); while (!s_tready);
    expected_perms.push_back(next_permutation(restart));
  endtask

  task automatic end_burst();
    s_tvalid <= 1'b0;
    s_tdata  <= '0;
  endtask

  // Result checker and receiver stalls; one tready assignment per edge
  result_t want;
  perm_t   got_elem;
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      got_elem = m_tdata;
      if (expected_perms.size() == 0) begin
        $error("result transfer with no request outstanding: %h", m_tdata);
        fail_count++;
      end else begin
        want = expected_perms.pop_front();
        for (int k = 0; k < MAX_SIZE; k++) begin
          if (got_elem[k] !== want.elem[k]) begin
            $error("elem_%0d: expected %0d, got %0d", k, want.elem[k], got_elem[k]);
            fail_count++;
          end
        end
        if (m_tlast !== want.is_final) begin
          $error("is_final: expected %0d, got %0d", want.is_final, m_tlast);
          fail_count++;
        end
      end
    end
    m_tready <= ($urandom_range(99) >= sink_stall_pct);
  end

  // Out of reset: size 3, first request gives identity without restart
  task automatic test_reset_defaults();
    send_request(1'b0);
    send_request(1'b0);
    send_request(1'b1);
    end_burst();
  endtask

  // Code zero is taken as one element; every request is "1" and final
  task automatic test_single_element();
    write_size('0);
    send_request(1'b0);
    send_request(1'b0);
    end_burst();
    write_size(SIZE_W'(1));
    send_request(1'b0);
    end_burst();
  endtask

  // All six of size 3, descending flagged, then wrap; restart mid-run
  task automatic test_wrap_size3();
    write_size(SIZE_W'(3));
    repeat (7) send_request(1'b0);
    send_request(1'b0);
    send_request(1'b1);
    end_burst();
  endtask

  // Oversize codes clamp to eight; each write restarts at identity
  task automatic test_size_saturation();
    write_size(4'hF);
    repeat (3) send_request(1'b0);
    end_burst();
    write_size(SIZE_W'(MAX_SIZE + 1));
    repeat (3) send_request(1'b0);
    end_burst();
    write_size(SIZE_W'(MAX_SIZE));
    send_request(1'b0);
    send_request(1'b1);
    end_burst();
  endtask

  // Random bursts between size writes; restart is rare so runs go deep
  task automatic test_random_requests(input int src_pct, input int sink_pct, input int count);
    int sent;
    int burst_len;
    src_idle_pct   = src_pct;
    sink_stall_pct = sink_pct;
    sent = 0;
    while (sent < count) begin
      write_size(random_size_code());
      burst_len = $urandom_range(60, 8);
      repeat (burst_len) begin
        send_request($urandom_range(99) < 4);
        sent++;
      end
      end_burst();
    end
  endtask

  initial begin
    int drain;
    perm_n       = SIZE_RESET;
    perm_started = 1'b0;
    load_identity_perm();
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_reset_defaults();
    test_single_element();
    test_wrap_size3();
    test_size_saturation();
    test_random_requests(21, 51, 630);
    test_random_requests(51, 21, 630);
    test_random_requests(0, 0, 630);

    // let the last results out, then a few quiet cycles
    drain = 0;
    while (expected_perms.size() != 0 && drain < 2000) begin
      @(posedge clk);
      drain++;
    end
    repeat (5) @(posedge clk);
    if (expected_perms.size() != 0) begin
      $error("%0d permutations never came out", expected_perms.size());
      fail_count++;
    end

    if (fail_count == 0) begin
      $display("lexicographic_permutation_stepper_tb OK");
    end else begin
      $display("lexicographic_permutation_stepper_tb NOT OK");
    end
    $finish;
  end

  // Hang guard, far beyond the slowest legal run
  initial begin
    #20_000_000;
    $display("lexicographic_permutation_stepper_tb NOT OK");
    $finish;
  end

endmodule
